FILE: rtl/zip_stored_entry_locator_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ZIP stored entry locator
// Shared property forms; each use expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ZIP_STORED_ENTRY_LOCATOR_DEFINES_SVH
`define ZIP_STORED_ENTRY_LOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ZSEL_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ZSEL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/zsel_pkg.sv
// ----------------------------------------------------------------------------
// zsel_pkg
// Word types and constants of the ZIP stored entry locator.
// ----------------------------------------------------------------------------
package zsel_pkg;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       end_of_file;
	} in_word_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       data_valid;
		logic [1:0] status;
		logic       last;
	} out_word_t;

	// Status codes
	localparam logic [1:0] ST_BUSY      = 2'd0;
	localparam logic [1:0] ST_FOUND     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_TRUNC     = 2'd3;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam logic [CFG_IDX_W-1:0] REG_NAME_LEN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NAME_W0  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NAME_W3  = 3'd4;
	localparam int NAME_LEN_W = 6;

	// Local file header layout
	localparam logic [31:0] LOCAL_SIG     = 32'h04034b50;
	localparam logic [4:0]  OFS_SIG_LAST  = 5'd3;
	localparam logic [4:0]  OFS_METHOD    = 5'd8;
	localparam logic [4:0]  OFS_COMP      = 5'd18;
	localparam logic [4:0]  OFS_UNCOMP    = 5'd22;
	localparam logic [4:0]  OFS_NAME_LEN  = 5'd26;
	localparam logic [4:0]  OFS_EXTRA_LEN = 5'd28;
	localparam logic [4:0]  HDR_LAST      = 5'd29;

endpackage

FILE: rtl/zsel_out_buf.sv
// ----------------------------------------------------------------------------
// zsel_out_buf
// Two-word result buffer; decouples the parser from output stalls.
// ----------------------------------------------------------------------------
module zsel_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  zsel_pkg::out_word_t push_word,
	output logic                full,
	output logic                out_valid,
	input  logic                out_ready,
	output zsel_pkg::out_word_t out_word
);
	import zsel_pkg::*;

	out_word_t  entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign pop       = out_valid && out_ready;
	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_word  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/zip_stored_entry_locator.sv
// ----------------------------------------------------------------------------
// zip_stored_entry_locator
// Streams a ZIP archive one byte per word, walks its local file headers and
// returns the data bytes of the entry whose name equals the configured target.
// Each accepted byte is handled in the cycle it arrives: a header field byte
// is captured into its field, a name byte is compared against the target,
// and a byte of an extra field, or of a non-matching entry's data, is counted off.
// The matching entry's data comes out one word per byte with status busy,
// the final one with status found and last set; an empty matching entry
// gives one word with status found. A bad signature, or an archive ending
// inside a header, name, extra field or skipped data, gives one not-found
// word; an archive ending inside the emitted data gives truncated. After the
// final word, bytes are swallowed until end_of_file, which always returns the
// parser to the start of a header (target registers are kept). Rate: one
// byte per clock while in_ready is high; the parser state updates once per
// accepted byte and results pass through a two-word buffer, so in_ready drops
// only while both buffer slots hold words the consumer has not taken. Result
// words are registered in the buffer, behind any not yet taken. Write the
// target registers only while the block is idle.
// ----------------------------------------------------------------------------
`include "zip_stored_entry_locator_defines.svh"

module zip_stored_entry_locator #(
	parameter int NAME_MAX_BYTES = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// byte stream in
	input  logic                                in_valid,
	output logic                                in_ready,
	input  zsel_pkg::in_word_t                  in_word,
	// result words out
	output logic                                out_valid,
	input  logic                                out_ready,
	output zsel_pkg::out_word_t                 out_word,
	// configuration writes
	input  logic                                cfg_wen,
	input  logic [zsel_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [zsel_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import zsel_pkg::*;

	localparam int IDX_W = (NAME_MAX_BYTES > 1) ? $clog2(NAME_MAX_BYTES) : 1;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_NAME,
		PH_EXTRA,
		PH_SKIP,
		PH_DATA,
		PH_DONE
	} phase_t;

	// Target name registers
	logic [NAME_LEN_W-1:0] tlen_q;
	logic [7:0]            target_q [NAME_MAX_BYTES];

	// Parser state
	phase_t      phase_q, phase_d;
	logic [31:0] cnt_q, cnt_d;
	logic [23:0] sig_q, sig_d;
	logic        method_nz_q, method_nz_d;
	logic [31:0] comp_q, comp_d;
	logic [31:0] uncomp_q, uncomp_d;
	logic [15:0] nm_len_q, nm_len_d;
	logic [15:0] xtra_len_q, xtra_len_d;
	logic        match_q, match_d;
	logic [15:0] name_idx_q, name_idx_d;

	// Step results
	logic        acc;
	logic        push;
	logic        buf_full;
	out_word_t   res;
	logic [7:0]  b;
	logic        eof;
	logic [4:0]  k;

	assign acc      = in_valid && in_ready;
	assign in_ready = !buf_full;
	assign b        = in_word.file_byte;
	assign eof      = in_word.end_of_file;
	assign k        = cnt_q[4:0];

	// Configuration writes: byte i of the target lives in word i/8, lane i%8.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlen_q <= '0;
			for (int i = 0; i < NAME_MAX_BYTES; i++) begin
				target_q[i] <= '0;
			end
		end else if (cfg_wen) begin
			if (cfg_index == REG_NAME_LEN) begin
				tlen_q <= cfg_wdata[NAME_LEN_W-1:0];
			end
			for (int i = 0; i < NAME_MAX_BYTES; i++) begin
				if (cfg_index == REG_NAME_W0 + CFG_IDX_W'(i >> 3)) begin
					target_q[i] <= cfg_wdata[8*(i & 7) +: 8];
				end
			end
		end
	end

	// One parser step per accepted byte.
	always_comb begin
		logic [4:0]  k_rel;
		logic        do_after_name;
		logic        do_finish;
		logic        mismatch;
		logic        rearm;
		logic [31:0] data_len;

		k_rel         = '0;
		do_after_name = 1'b0;
		do_finish     = 1'b0;
		mismatch      = 1'b0;
		rearm         = 1'b0;
		data_len      = '0;

		phase_d     = phase_q;
		cnt_d       = cnt_q;
		sig_d       = sig_q;
		method_nz_d = method_nz_q;
		comp_d      = comp_q;
		uncomp_d    = uncomp_q;
		nm_len_d    = nm_len_q;
		xtra_len_d  = xtra_len_q;
		match_d     = match_q;
		name_idx_d  = name_idx_q;

		push = 1'b0;
		res  = '{data_byte: 8'd0, data_valid: 1'b0, status: ST_BUSY, last: 1'b0};

		case (phase_q)
			PH_HEADER: begin
				// capture the field this offset belongs to
				case (k) inside
					[5'd0:5'd2]: begin
						sig_d[{k[1:0], 3'b000} +: 8] = b;
					end
					OFS_METHOD, OFS_METHOD + 5'd1: begin
						if (b != 8'd0) begin
							method_nz_d = 1'b1;
						end
					end
					[OFS_COMP:OFS_COMP + 5'd3]: begin
						k_rel = k - OFS_COMP;
						comp_d[{k_rel[1:0], 3'b000} +: 8] = b;
					end
					[OFS_UNCOMP:OFS_UNCOMP + 5'd3]: begin
						k_rel = k - OFS_UNCOMP;
						uncomp_d[{k_rel[1:0], 3'b000} +: 8] = b;
					end
					OFS_NAME_LEN, OFS_NAME_LEN + 5'd1: begin
						nm_len_d[{k[0], 3'b000} +: 8] = b;
					end
					OFS_EXTRA_LEN, OFS_EXTRA_LEN + 5'd1: begin
						xtra_len_d[{k[0], 3'b000} +: 8] = b;
					end
					default: ;
				endcase
				cnt_d = cnt_q + 32'd1;
				if (k == OFS_SIG_LAST && {b, sig_q} != LOCAL_SIG) begin
					phase_d = PH_DONE;
					push    = 1'b1;
					res     = '{data_byte: 8'd0, data_valid: 1'b0,
						status: ST_NOT_FOUND, last: 1'b1};
				end else if (k == HDR_LAST) begin
					match_d = (nm_len_d == {{(16 - NAME_LEN_W){1'b0}}, tlen_q}) &&
						(tlen_q <= NAME_LEN_W'(NAME_MAX_BYTES));
					name_idx_d = '0;
					if (nm_len_d != 16'd0) begin
						phase_d = PH_NAME;
					end else begin
						do_after_name = 1'b1;
					end
				end
			end
			PH_NAME: begin
				mismatch = (name_idx_q >= {{(16 - NAME_LEN_W){1'b0}}, tlen_q}) ||
					(name_idx_q >= 16'(NAME_MAX_BYTES)) ||
					(target_q[name_idx_q[IDX_W-1:0]] != b);
				if (mismatch) begin
					match_d = 1'b0;
				end
				name_idx_d = name_idx_q + 16'd1;
				if (name_idx_d >= nm_len_q) begin
					do_after_name = 1'b1;
				end
			end
			PH_EXTRA: begin
				cnt_d = cnt_q + 32'd1;
				if (cnt_d >= {16'd0, xtra_len_q}) begin
					do_finish = 1'b1;
				end
			end
			PH_SKIP: begin
				cnt_d = cnt_q - 32'd1;
				if (cnt_d == 32'd0) begin
					phase_d = PH_HEADER;
				end
			end
			PH_DATA: begin
				cnt_d = cnt_q - 32'd1;
				push  = 1'b1;
				if (cnt_d == 32'd0) begin
					phase_d = PH_DONE;
					res = '{data_byte: b, data_valid: 1'b1, status: ST_FOUND, last: 1'b1};
				end else if (eof) begin
					res = '{data_byte: b, data_valid: 1'b1, status: ST_TRUNC, last: 1'b1};
				end else begin
					res = '{data_byte: b, data_valid: 1'b1, status: ST_BUSY, last: 1'b0};
				end
			end
			default: ;
		endcase

		// name done: go through the extra field, or straight to the entry decision
		if (do_after_name) begin
			cnt_d = '0;
			if (xtra_len_d != 16'd0) begin
				phase_d = PH_EXTRA;
			end else begin
				do_finish = 1'b1;
			end
		end

		// entry decision: emit the matching entry's data, skip any other
		if (do_finish) begin
			data_len = method_nz_d ? comp_d : uncomp_d;
			if (match_d) begin
				if (data_len == 32'd0) begin
					phase_d = PH_DONE;
					push    = 1'b1;
					res     = '{data_byte: 8'd0, data_valid: 1'b0,
						status: ST_FOUND, last: 1'b1};
				end else begin
					phase_d = PH_DATA;
					cnt_d   = data_len;
				end
			end else if (comp_d != 32'd0) begin
				phase_d = PH_SKIP;
				cnt_d   = comp_d;
			end else begin
				// nothing to skip: the next header follows at once
				phase_d = PH_HEADER;
				rearm   = 1'b1;
			end
		end

		// end of archive: report if nothing final went out yet, then rearm
		if (eof) begin
			if (!push && phase_q != PH_DONE) begin
				push = 1'b1;
				res  = '{data_byte: 8'd0, data_valid: 1'b0,
					status: (phase_d == PH_DATA) ? ST_TRUNC : ST_NOT_FOUND, last: 1'b1};
			end
			phase_d = PH_HEADER;
		end

		// a fresh header starts with cleared fields
		if (phase_d == PH_HEADER && (phase_q != PH_HEADER || eof || rearm)) begin
			cnt_d       = '0;
			sig_d       = '0;
			method_nz_d = 1'b0;
			comp_d      = '0;
			uncomp_d    = '0;
			nm_len_d    = '0;
			xtra_len_d  = '0;
			match_d     = 1'b1;
			name_idx_d  = '0;
		end

		if (!acc) begin
			push = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			cnt_q       <= '0;
			sig_q       <= '0;
			method_nz_q <= 1'b0;
			comp_q      <= '0;
			uncomp_q    <= '0;
			nm_len_q    <= '0;
			xtra_len_q  <= '0;
			match_q     <= 1'b1;
			name_idx_q  <= '0;
		end else if (acc) begin
			phase_q     <= phase_d;
			cnt_q       <= cnt_d;
			sig_q       <= sig_d;
			method_nz_q <= method_nz_d;
			comp_q      <= comp_d;
			uncomp_q    <= uncomp_d;
			nm_len_q    <= nm_len_d;
			xtra_len_q  <= xtra_len_d;
			match_q     <= match_d;
			name_idx_q  <= name_idx_d;
		end
	end

	// Hold result words until the consumer takes them.
	zsel_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	`ZSEL_ASSERT(a_no_overflow, push, !buf_full, "result pushed into a full buffer")
	`ZSEL_ASSERT(a_data_count, phase_q == PH_DATA, cnt_q != 32'd0, "data phase, zero count")
	`ZSEL_ASSERT(a_hdr_cnt, phase_q == PH_HEADER, cnt_q <= 32'(HDR_LAST), "bad header offset")
	`ZSEL_ASSERT(a_done_quiet, acc && phase_q == PH_DONE && !eof, !push, "late result")
	`ZSEL_ASSERT_NEXT(a_eof_rearm, acc && eof, phase_q == PH_HEADER && cnt_q == 32'd0, "no rearm")

endmodule
